@@ rtl/ptq_pkg.sv @@
// Package for the paced transmit packet queue.
// Holds the shared codes, payload structs and sizing constants; no dependencies.
package ptq_pkg;

   localparam int QUEUE_DEPTH_DEF  = 8;
   localparam int PACKET_BYTES_DEF = 64;

   // Widest slot index and packet length carried between the front and the back.
   localparam int SLOT_MAX_W = 6;
   localparam int LEN_MAX_W  = 7;

   // Command queue between the front and the back, and result queue at the output.
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = 2;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int PEND_W    = 3;

   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_DONE    = 2'd2;
   localparam logic [1:0] OP_REFRESH = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_LEN    = 3'd2;
   localparam logic [2:0] ST_BUSY   = 3'd3;
   localparam logic [2:0] ST_NODATA = 3'd4;

   localparam logic [31:0] TICKS_MAX     = 32'hFFFF_FFFF;
   localparam logic [31:0] MIN_GAP_RESET = 32'd1000;

   typedef enum logic [1:0] {
      REJ_NONE,
      REJ_FULL,
      REJ_LEN
   } reject_type;

   typedef enum logic {
      BK_IDLE,
      BK_SEND
   } back_state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_type;

   // One unit of work for the back: either a single status word or a packet to send.
   typedef struct packed {
      logic                  is_send;
      logic [2:0]            status;
      logic [SLOT_MAX_W-1:0] slot;
      logic [LEN_MAX_W-1:0]  len;
   } cmd_type;

endpackage

@@ rtl/ptq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module ptq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ptq_cmd_fifo.sv @@
// Short command queue between the front and the back of the packet queue.
// Depends on ptq_pkg for the command struct and depth.
module ptq_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptq_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output ptq_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int PW = ptq_pkg::CMD_PTR_W;

   ptq_pkg::cmd_type mem_ff [ptq_pkg::CMD_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full    = (count_ff == (PW+1)'(ptq_pkg::CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

endmodule

@@ rtl/ptq_front.sv @@
// Front of the packet queue: takes input words, keeps the queue bookkeeping,
// the tick counter and the gap register, and hands commands to the back.
// Depends on ptq_pkg.
module ptq_front #(
   parameter int QUEUE_DEPTH  = ptq_pkg::QUEUE_DEPTH_DEF,
   parameter int PACKET_BYTES = ptq_pkg::PACKET_BYTES_DEF,
   parameter int ADDR_W = (QUEUE_DEPTH * PACKET_BYTES > 1) ?
                          $clog2(QUEUE_DEPTH * PACKET_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  ptq_pkg::req_type  req_word,
   output logic              req_full,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data,
   output logic              cmd_push,
   output ptq_pkg::cmd_type  cmd_word,
   input  logic              cmd_full,
   input  logic              send_done,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]        ram_wr_data
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LEN_W  = $clog2(PACKET_BYTES + 1);
   localparam int SUM_W  = CNT_W + 1;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [SLOT_W-1:0]         head_ff, head_in;
   logic [LEN_W-1:0]          fill_ff, fill_in;
   ptq_pkg::reject_type       rej_ff, rej_in;
   logic                      busy_ff, busy_in;
   logic [31:0]               elapsed_ff, elapsed_in;
   logic [31:0]               gap_ff, gap_in;
   logic [ptq_pkg::PEND_W-1:0] pend_ff, pend_in;
   logic [LEN_W-1:0]          lengths_ff [QUEUE_DEPTH];

   logic                accept;
   logic [SUM_W-1:0]    tail_sum;
   logic [SLOT_W-1:0]   tail;
   logic [SLOT_W-1:0]   head_next;
   ptq_pkg::reject_type rej_now;
   logic                len_wr;
   logic                push_send;

   assign req_full  = cmd_full ||
                      ((pend_ff != '0) && (req_word.operation == ptq_pkg::OP_BYTE));
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
   assign head_next = (head_ff == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   always_comb begin
      count_in    = count_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      rej_in      = rej_ff;
      busy_in     = busy_ff;
      elapsed_in  = elapsed_ff;
      gap_in      = gap_ff;
      cmd_push    = 1'b0;
      cmd_word    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = ADDR_W'(tail * PACKET_BYTES + fill_ff);
      ram_wr_data = req_word.data_byte;
      len_wr      = 1'b0;
      push_send   = 1'b0;
      rej_now     = rej_ff;

      if (csr_valid) begin
         gap_in = csr_data;
      end

      if (accept) begin
         case (req_word.operation)
            ptq_pkg::OP_BYTE: begin
               if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                  rej_now = ptq_pkg::REJ_FULL;
               end else if ((rej_ff == ptq_pkg::REJ_NONE) &&
                            (fill_ff >= LEN_W'(PACKET_BYTES))) begin
                  rej_now = ptq_pkg::REJ_LEN;
               end
               rej_in = rej_now;
               if (rej_now == ptq_pkg::REJ_NONE) begin
                  ram_wr_en = 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end
               if (req_word.last_byte) begin
                  cmd_push        = 1'b1;
                  cmd_word.status = ptq_pkg::ST_OK;
                  if (rej_now == ptq_pkg::REJ_FULL) begin
                     cmd_word.status = ptq_pkg::ST_FULL;
                  end else if (rej_now == ptq_pkg::REJ_LEN) begin
                     cmd_word.status = ptq_pkg::ST_LEN;
                  end else begin
                     len_wr   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
                  fill_in = '0;
                  rej_in  = ptq_pkg::REJ_NONE;
               end
            end
            ptq_pkg::OP_TICK: begin
               if (elapsed_ff != ptq_pkg::TICKS_MAX) begin
                  elapsed_in = elapsed_ff + 1'b1;
               end
            end
            ptq_pkg::OP_DONE: begin
               busy_in    = 1'b0;
               elapsed_in = '0;
            end
            default: begin
               cmd_push        = 1'b1;
               cmd_word.status = ptq_pkg::ST_BUSY;
               if (!busy_ff) begin
                  elapsed_in = '0;
                  if (elapsed_ff <= gap_ff) begin
                     cmd_word.status = ptq_pkg::ST_BUSY;
                  end else if (count_ff == '0) begin
                     cmd_word.status = ptq_pkg::ST_NODATA;
                  end else begin
                     cmd_word.status  = ptq_pkg::ST_OK;
                     cmd_word.is_send = 1'b1;
                     cmd_word.slot    = ptq_pkg::SLOT_MAX_W'(head_ff);
                     cmd_word.len     = ptq_pkg::LEN_MAX_W'(lengths_ff[head_ff]);
                     head_in          = head_next;
                     count_in         = count_ff - 1'b1;
                     busy_in          = 1'b1;
                     push_send        = 1'b1;
                  end
               end
            end
         endcase
      end

      // A popped slot stays reserved until the back has read its last byte.
      pend_in = pend_ff + ptq_pkg::PEND_W'(push_send) - ptq_pkg::PEND_W'(send_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         head_ff    <= '0;
         fill_ff    <= '0;
         rej_ff     <= ptq_pkg::REJ_NONE;
         busy_ff    <= 1'b0;
         elapsed_ff <= '0;
         gap_ff     <= ptq_pkg::MIN_GAP_RESET;
         pend_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         head_ff    <= head_in;
         fill_ff    <= fill_in;
         rej_ff     <= rej_in;
         busy_ff    <= busy_in;
         elapsed_ff <= elapsed_in;
         gap_ff     <= gap_in;
         pend_ff    <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (len_wr) begin
         lengths_ff[tail] <= fill_ff + 1'b1;
      end
   end

endmodule

@@ rtl/ptq_back.sv @@
// Back of the packet queue: executes commands, streams packet bytes out of
// the packet RAM and buffers result words for the receiver. Depends on ptq_pkg.
module ptq_back #(
   parameter int QUEUE_DEPTH  = ptq_pkg::QUEUE_DEPTH_DEF,
   parameter int PACKET_BYTES = ptq_pkg::PACKET_BYTES_DEF,
   parameter int ADDR_W = (QUEUE_DEPTH * PACKET_BYTES > 1) ?
                          $clog2(QUEUE_DEPTH * PACKET_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  ptq_pkg::cmd_type  cmd_word,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output logic              send_done,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]        ram_rd_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ptq_pkg::rsp_type  rsp_word
);

   localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEN_W  = $clog2(PACKET_BYTES + 1);
   localparam int PW     = ptq_pkg::OUT_PTR_W;

   ptq_pkg::back_state_type state_ff, state_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [LEN_W-1:0]        idx_ff, idx_in;

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_byte_ff, s1_byte_in;
   ptq_pkg::rsp_type        s1_ff, s1_in;

   ptq_pkg::rsp_type        out_mem_ff [ptq_pkg::OUT_DEPTH];
   logic [PW-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]             out_count_ff, out_count_in;
   ptq_pkg::rsp_type        push_word;
   logic                    out_pop;
   logic                    credit;
   logic                    last_idx;

   // Room for the word in flight plus the one issued now.
   assign credit   = ((out_count_ff + (PW+1)'(s1_valid_ff)) < (PW+1)'(ptq_pkg::OUT_DEPTH));
   assign last_idx = ((idx_ff + 1'b1) == len_ff);

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      len_in      = len_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      send_done   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(slot_ff * PACKET_BYTES + idx_ff);
      s1_valid_in = 1'b0;
      s1_byte_in  = 1'b0;
      s1_in       = '0;
      case (state_ff)
         ptq_pkg::BK_IDLE: begin
            if (!cmd_empty && credit) begin
               cmd_pop = 1'b1;
               if (cmd_word.is_send) begin
                  state_in = ptq_pkg::BK_SEND;
                  slot_in  = SLOT_W'(cmd_word.slot);
                  len_in   = LEN_W'(cmd_word.len);
                  idx_in   = '0;
               end else begin
                  s1_valid_in    = 1'b1;
                  s1_in.status   = cmd_word.status;
                  s1_in.tx_last  = 1'b1;
               end
            end
         end
         ptq_pkg::BK_SEND: begin
            if (credit) begin
               ram_rd_en      = 1'b1;
               s1_valid_in    = 1'b1;
               s1_byte_in     = 1'b1;
               s1_in.status   = ptq_pkg::ST_OK;
               s1_in.tx_valid = 1'b1;
               s1_in.tx_last  = last_idx;
               if (last_idx) begin
                  state_in  = ptq_pkg::BK_IDLE;
                  send_done = 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ptq_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      push_word = s1_ff;
      if (s1_byte_ff) begin
         push_word.tx_byte = ram_rd_data;
      end
   end

   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_word  = out_mem_ff[rd_ptr_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (s1_valid_ff && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_pop && !s1_valid_ff) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptq_pkg::BK_IDLE;
         s1_valid_ff  <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_count_ff <= out_count_in;
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (out_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff    <= slot_in;
      len_ff     <= len_in;
      idx_ff     <= idx_in;
      s1_byte_ff <= s1_byte_in;
      s1_ff      <= s1_in;
      if (s1_valid_ff) begin
         out_mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ rtl/paced_tx_packet_queue.sv @@
// Top level of the paced transmit packet queue.
// Uses ptq_pkg, ptq_ram, ptq_front, ptq_cmd_fifo and ptq_back.
//
// Usage:
//   The request side is a queue input: drive req_word and raise req_push; the
//   word is taken at a clock edge where req_full is low. A word is a packet
//   byte, a time tick, a transfer-complete notice or a refresh poll.
//   The response side is a queue output: while rsp_empty is low, rsp_word holds
//   the oldest result word, and raising rsp_pop removes it.
//   csr_valid/csr_ready write the minimum gap in ticks; csr_ready is always high.
//   A status word goes from the command queue through the back's stage register
//   into the output buffer, a packet byte from the send state through the RAM read
//   register. A refresh that sends a packet produces one byte word per cycle for
//   the packet length while the output buffer has room, paced by the single read
//   port of the packet RAM. Throughput: one request word per cycle, except that
//   packet bytes are held off while a sent packet is still being read out of the
//   RAM. When the receiver stalls, a four-word output buffer fills, the back stops
//   reading, the four-entry command queue fills, and then req_full rises.
//   Reset is synchronous; it empties both queues, clears the packet queue and
//   tick counter and restores the gap register to 1000. No clearing pass runs.
module paced_tx_packet_queue #(
   parameter int QUEUE_DEPTH  = ptq_pkg::QUEUE_DEPTH_DEF,
   parameter int PACKET_BYTES = ptq_pkg::PACKET_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  ptq_pkg::req_type req_word,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output ptq_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);

   localparam int RAM_DEPTH = QUEUE_DEPTH * PACKET_BYTES;
   localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

   logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
   ptq_pkg::cmd_type  cmd_in_word, cmd_out_word;
   logic              send_done;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   ptq_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PACKET_BYTES(PACKET_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_word   (req_word),
      .req_full   (req_full),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd_push   (cmd_push),
      .cmd_word   (cmd_in_word),
      .cmd_full   (cmd_full),
      .send_done  (send_done),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data)
   );

   ptq_cmd_fifo u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .push_cmd(cmd_in_word),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .pop_cmd (cmd_out_word),
      .empty   (cmd_empty)
   );

   ptq_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_packet_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   ptq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .PACKET_BYTES(PACKET_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_word   (cmd_out_word),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .send_done  (send_done),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

   // A word without a packet byte is always the last of its run and carries a zero byte.
   a_status_word_form: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_word.tx_valid) |-> (rsp_word.tx_last && rsp_word.tx_byte == 8'd0))
      else $error("status word with byte or without last flag");

   // Packet bytes always carry status ok.
   a_byte_status_ok: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_word.tx_valid) |-> (rsp_word.status == ptq_pkg::ST_OK))
      else $error("packet byte with non-ok status");

   // The packet RAM is never written and read in the same cycle.
   a_ram_exclusive: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !ram_rd_en)
      else $error("packet RAM written during a send");

   // Right after reset the result side is empty.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("results present after reset");

endmodule
